[src/rpzp_pkg.sv]
// rpzp_pkg: shared types and constants of the rotate/project/z-buffer plotter
// holds the state and command enums, the register map, the config struct and fixed widths
// no dependencies
package rpzp_pkg;

  // shared multiplier operand width
  localparam int MUL_W  = 33;

  // z in Q.16 and 1/z in Q1.24
  localparam int ZQ_W   = 27;
  localparam int INV_W  = 25;
  localparam int GLYPH_W = 8;

  localparam logic [INV_W-1:0] INV_ONE = 25'h100_0000;
  localparam logic [ZQ_W-1:0]  ZQ_MIN  = 27'd65536;
  // 2^40 / 2^25 : remainder after the leading quotient bits that are always zero
  localparam logic [ZQ_W:0]    DIV_REM_INIT = 28'd32768;

  localparam int Q14_SHIFT  = 14;
  localparam int FRAC_SHIFT = 34;
  localparam int PROJ_SHIFT = 40;
  localparam int CAM_SHIFT  = 50;

  // schedule lengths of the shared multiplier
  localparam logic [4:0] MUL_LAST  = 5'd16;
  localparam logic [4:0] PROJ_LAST = 5'd3;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [15:0] ONE_Q14      = 16'sd16384;
  localparam logic [7:0]         CAM_RESET    = 8'd100;
  localparam logic [7:0]         ZOOM_RESET   = 8'd40;

  typedef enum logic [1:0] {
    CMD_PLOT  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIN_A  = 3'd0,
    REG_COS_A  = 3'd1,
    REG_SIN_B  = 3'd2,
    REG_COS_B  = 3'd3,
    REG_SIN_C  = 3'd4,
    REG_COS_C  = 3'd5,
    REG_CAMERA = 3'd6,
    REG_ZOOM   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_INV,
    ST_DIV,
    ST_PROJ,
    ST_INDEX,
    ST_ADDR,
    ST_LOOK,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic signed [15:0] sin_a;
    logic signed [15:0] cos_a;
    logic signed [15:0] sin_b;
    logic signed [15:0] cos_b;
    logic signed [15:0] sin_c;
    logic signed [15:0] cos_c;
    logic [7:0]         camera_distance;
    logic [7:0]         zoom;
  } cfg_t;

endpackage

[src/rpzp_ram.sv]
// rpzp_ram: generic single write port, single read port ram with registered read
// no dependencies
module rpzp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/rpzp_mul.sv]
// rpzp_mul: shared signed multiplier with a registered product
// no dependencies
module rpzp_mul #(
  parameter int W = 33
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[src/rpzp_div.sv]
// rpzp_div: radix-2 divider forming 2^40 / zq, one quotient bit per cycle
// depends on rpzp_pkg for widths; divisor must be at least 2^16
module rpzp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rpzp_pkg::ZQ_W-1:0]     divisor,
  output logic                          done,
  output logic [rpzp_pkg::INV_W-1:0]    quot
);

  logic                       run;
  logic [4:0]                 bit_cnt;
  logic [rpzp_pkg::ZQ_W-1:0]  d;
  logic [rpzp_pkg::ZQ_W:0]    rem;
  logic [rpzp_pkg::ZQ_W:0]    rem_sh;
  logic                       fits;

  assign rem_sh = {rem[rpzp_pkg::ZQ_W-1:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run     <= 1'b1;
        bit_cnt <= 5'(rpzp_pkg::INV_W - 1);
        d       <= divisor;
        rem     <= rpzp_pkg::DIV_REM_INIT;
        quot    <= '0;
      end else if (run) begin
        rem  <= fits ? rem_sh - {1'b0, d} : rem_sh;
        quot <= {quot[rpzp_pkg::INV_W-2:0], fits};
        bit_cnt <= bit_cnt - 5'd1;
        if (bit_cnt == 5'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/rpzp_cfg.sv]
// rpzp_cfg: configuration register file (angles, camera distance, zoom)
// depends on rpzp_pkg for the register map and the config struct
module rpzp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [rpzp_pkg::CFG_IDX_W-1:0] index,
  input  logic [rpzp_pkg::CFG_W-1:0]     data,
  output rpzp_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sin_a <= '0;
      cfg.cos_a <= rpzp_pkg::ONE_Q14;
      cfg.sin_b <= '0;
      cfg.cos_b <= rpzp_pkg::ONE_Q14;
      cfg.sin_c <= '0;
      cfg.cos_c <= rpzp_pkg::ONE_Q14;
      cfg.camera_distance <= rpzp_pkg::CAM_RESET;
      cfg.zoom  <= rpzp_pkg::ZOOM_RESET;
    end else if (we) begin
      case (rpzp_pkg::reg_idx_t'(index))
        rpzp_pkg::REG_SIN_A:  cfg.sin_a <= signed'(data);
        rpzp_pkg::REG_COS_A:  cfg.cos_a <= signed'(data);
        rpzp_pkg::REG_SIN_B:  cfg.sin_b <= signed'(data);
        rpzp_pkg::REG_COS_B:  cfg.cos_b <= signed'(data);
        rpzp_pkg::REG_SIN_C:  cfg.sin_c <= signed'(data);
        rpzp_pkg::REG_COS_C:  cfg.cos_c <= signed'(data);
        rpzp_pkg::REG_CAMERA: cfg.camera_distance <= data[7:0];
        rpzp_pkg::REG_ZOOM:   cfg.zoom <= data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[src/rotate_project_zbuffer_plot_top.sv]
// rotate_project_zbuffer_plot_top: command-driven point plotter with a depth/glyph buffer
// depends on rpzp_pkg, rpzp_cfg, rpzp_mul, rpzp_div and rpzp_ram
//
// One command at a time: a command transfers on a clock edge with start high and busy low,
// and its single result shows on drawn, pixel_index and glyph_out for exactly one cycle with
// done high; the receiver cannot stall, so the result must be taken then. A plot rotates the
// point with one shared 33x33 multiplier over 16 products; when z is under one unit 1/z is set
// to one, otherwise the 1/z divider forms its 25 quotient bits. Projection follows on the same
// multiplier, then the index, the address, the buffer read and the compare/write-back. A point
// that lands off screen answers from the buffer read without the write-back, a point behind the
// camera from the check that follows the rotation. A read goes straight to the buffer read and
// answers from the compare/write-back step (from the buffer read when out of range), cmd 3
// straight from idle. A clear sweeps the combined depth/glyph memory one entry a cycle,
// SCREEN_WIDTH*SCREEN_HEIGHT entries (7040 by default); the same sweep runs after reset with
// busy high and no result. Configuration writes are taken at any time but belong between
// commands.
module rotate_project_zbuffer_plot_top #(
  parameter int SCREEN_WIDTH     = 160,
  parameter int SCREEN_HEIGHT    = 44,
  parameter int BACKGROUND_GLYPH = 46
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     cmd,
  input  logic signed [13:0]             pos_i,
  input  logic signed [13:0]             pos_j,
  input  logic signed [13:0]             pos_k,
  input  logic signed [7:0]              shift_x,
  input  logic [7:0]                     glyph,
  input  logic [12:0]                    read_index,
  input  logic                           cfg_we,
  input  logic [rpzp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpzp_pkg::CFG_W-1:0]     cfg_data,
  output logic                           done,
  output logic                           drawn,
  output logic [12:0]                    pixel_index,
  output logic [7:0]                     glyph_out
);

  localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW     = $clog2(CELLS);
  localparam int HALF_W = SCREEN_WIDTH / 2;
  localparam int HALF_H = SCREEN_HEIGHT / 2;
  localparam int MW     = rpzp_pkg::MUL_W;
  localparam int IW     = rpzp_pkg::INV_W;
  localparam int GW     = rpzp_pkg::GLYPH_W;
  localparam int DW     = IW + GW;

  function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] v,
                                                     input int unsigned n);
    logic signed [63:0] bias;
    bias = (64'sd1 <<< n) - 64'sd1;
    return (v + (v < 0 ? bias : 64'sd0)) >>> n;
  endfunction

  rpzp_pkg::state_t state, state_next;
  rpzp_pkg::cfg_t   cfg;

  logic [1:0]               op;
  logic signed [13:0]       pi, pj, pk;
  logic signed [7:0]        sh;
  logic [GW-1:0]            gl;
  logic [4:0]               cnt;
  logic signed [MW-1:0]     pp, qq, sbcc, sbsc, cbcc, cbsc;
  logic signed [63:0]       xf, yf, zf, sx, sy;
  logic signed [MW-1:0]     xq, yq, zi;
  logic [rpzp_pkg::ZQ_W-1:0] zq;
  logic [IW-1:0]            inv;
  logic signed [23:0]       xp, yp;
  logic signed [39:0]       idx;
  logic [AW-1:0]            clr_addr;
  logic                     clr_emit;
  logic                     clr_last;
  logic                     in_range;

  logic signed [MW-1:0]         ma, mb;
  logic signed [2*MW-1:0]       prod;
  logic signed [63:0]           p64;

  logic                         div_start, div_done;
  logic [IW-1:0]                div_quot;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [DW-1:0]                ram_wdata, ram_rdata;
  logic                         nearer;

  assign p64      = signed'(prod[63:0]);
  assign clr_last = clr_addr == AW'(CELLS - 1);
  assign in_range = !idx[39] && (idx < 40'(CELLS));
  assign nearer   = inv > ram_rdata[DW-1:GW];

  rpzp_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  rpzp_mul #(.W(MW)) u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (prod)
  );

  rpzp_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (zq),
    .done    (div_done),
    .quot    (div_quot)
  );

  rpzp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpzp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = state != rpzp_pkg::ST_IDLE;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx[AW-1:0];
    ram_raddr  = idx[AW-1:0];
    ram_wdata  = {inv, gl};
    case (state)
      rpzp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = {{IW{1'b0}}, GW'(BACKGROUND_GLYPH)};
        if (clr_last) state_next = rpzp_pkg::ST_IDLE;
      end
      rpzp_pkg::ST_IDLE: begin
        if (start) begin
          case (rpzp_pkg::cmd_t'(cmd))
            rpzp_pkg::CMD_PLOT:  state_next = rpzp_pkg::ST_MUL;
            rpzp_pkg::CMD_CLEAR: state_next = rpzp_pkg::ST_CLEAR;
            rpzp_pkg::CMD_READ:  state_next = rpzp_pkg::ST_LOOK;
            default:             state_next = rpzp_pkg::ST_IDLE;
          endcase
        end
      end
      rpzp_pkg::ST_MUL: begin
        if (cnt == rpzp_pkg::MUL_LAST) state_next = rpzp_pkg::ST_CHK;
      end
      rpzp_pkg::ST_CHK: begin
        state_next = (zf <= 64'sd0) ? rpzp_pkg::ST_IDLE : rpzp_pkg::ST_INV;
      end
      rpzp_pkg::ST_INV: begin
        if (zq < rpzp_pkg::ZQ_MIN) begin
          state_next = rpzp_pkg::ST_PROJ;
        end else begin
          div_start  = 1'b1;
          state_next = rpzp_pkg::ST_DIV;
        end
      end
      rpzp_pkg::ST_DIV: begin
        if (div_done) state_next = rpzp_pkg::ST_PROJ;
      end
      rpzp_pkg::ST_PROJ: begin
        if (cnt == rpzp_pkg::PROJ_LAST) state_next = rpzp_pkg::ST_INDEX;
      end
      rpzp_pkg::ST_INDEX: state_next = rpzp_pkg::ST_ADDR;
      rpzp_pkg::ST_ADDR:  state_next = rpzp_pkg::ST_LOOK;
      rpzp_pkg::ST_LOOK: begin
        state_next = in_range ? rpzp_pkg::ST_UPDATE : rpzp_pkg::ST_IDLE;
      end
      rpzp_pkg::ST_UPDATE: begin
        // read-modify-write of the depth/glyph entry
        ram_we     = (op == rpzp_pkg::CMD_PLOT) && nearer;
        state_next = rpzp_pkg::ST_IDLE;
      end
      default: state_next = rpzp_pkg::ST_IDLE;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      rpzp_pkg::ST_MUL: begin
        case (cnt)
          5'd0:  begin ma = MW'(pj);   mb = MW'(cfg.sin_a); end
          5'd1:  begin ma = MW'(pk);   mb = MW'(cfg.cos_a); end
          5'd2:  begin ma = MW'(pj);   mb = MW'(cfg.cos_a); end
          5'd3:  begin ma = MW'(pk);   mb = MW'(cfg.sin_a); end
          5'd4:  begin ma = MW'(cfg.sin_b); mb = MW'(cfg.cos_c); end
          5'd5:  begin ma = MW'(cfg.sin_b); mb = MW'(cfg.sin_c); end
          5'd6:  begin ma = MW'(cfg.cos_b); mb = MW'(cfg.cos_c); end
          5'd7:  begin ma = MW'(cfg.cos_b); mb = MW'(cfg.sin_c); end
          5'd8:  begin ma = sbcc;      mb = pp; end
          5'd9:  begin ma = MW'(cfg.sin_c); mb = qq; end
          5'd10: begin ma = cbcc;      mb = MW'(pi); end
          5'd11: begin ma = MW'(cfg.cos_c); mb = qq; end
          5'd12: begin ma = sbsc;      mb = pp; end
          5'd13: begin ma = cbsc;      mb = MW'(pi); end
          5'd14: begin ma = MW'(cfg.cos_b); mb = pp; end
          5'd15: begin ma = MW'(cfg.sin_b); mb = MW'(pi); end
          default: begin
          end
        endcase
      end
      rpzp_pkg::ST_PROJ: begin
        case (cnt)
          5'd0: begin ma = MW'(cfg.zoom); mb = MW'(inv); end
          5'd1: begin ma = signed'(prod[MW-1:0]); mb = xq; end
          5'd2: begin ma = zi; mb = yq; end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      clr_emit    <= 1'b0;
      cnt         <= '0;
      done        <= 1'b0;
      drawn       <= 1'b0;
      pixel_index <= '0;
      glyph_out   <= '0;
    end else begin
      done        <= 1'b0;
      drawn       <= 1'b0;
      pixel_index <= '0;
      glyph_out   <= '0;
      case (state)
        rpzp_pkg::ST_CLEAR: begin
          clr_addr <= clr_last ? '0 : clr_addr + AW'(1);
          if (clr_last) begin
            clr_emit <= 1'b0;
            done     <= clr_emit;
          end
        end
        rpzp_pkg::ST_IDLE: begin
          cnt <= '0;
          if (start) begin
            op  <= cmd;
            pi  <= pos_i;
            pj  <= pos_j;
            pk  <= pos_k;
            sh  <= shift_x;
            gl  <= glyph;
            idx <= 40'(read_index);
            case (rpzp_pkg::cmd_t'(cmd))
              rpzp_pkg::CMD_CLEAR: begin
                clr_emit <= 1'b1;
                clr_addr <= '0;
              end
              rpzp_pkg::CMD_NONE: done <= 1'b1;
              default: begin
              end
            endcase
          end
        end
        rpzp_pkg::ST_MUL: begin
          cnt <= (cnt == rpzp_pkg::MUL_LAST) ? 5'd0 : cnt + 5'd1;
          // prod holds the product issued one step earlier
          case (cnt)
            5'd1:  pp   <= signed'(prod[MW-1:0]);
            5'd2:  pp   <= pp - signed'(prod[MW-1:0]);
            5'd3:  qq   <= signed'(prod[MW-1:0]);
            5'd4:  qq   <= qq + signed'(prod[MW-1:0]);
            5'd5:  sbcc <= signed'(prod[MW-1:0]);
            5'd6:  sbsc <= signed'(prod[MW-1:0]);
            5'd7:  cbcc <= signed'(prod[MW-1:0]);
            5'd8:  cbsc <= signed'(prod[MW-1:0]);
            5'd9:  xf   <= p64;
            5'd10: xf   <= xf + (p64 <<< rpzp_pkg::Q14_SHIFT);
            5'd11: xf   <= xf + (p64 <<< rpzp_pkg::Q14_SHIFT);
            5'd12: yf   <= p64 <<< rpzp_pkg::Q14_SHIFT;
            5'd13: yf   <= yf - p64;
            5'd14: yf   <= yf - (p64 <<< rpzp_pkg::Q14_SHIFT);
            5'd15: zf   <= (signed'(64'(cfg.camera_distance)) <<< rpzp_pkg::CAM_SHIFT)
                           - (p64 <<< rpzp_pkg::Q14_SHIFT);
            5'd16: zf   <= zf + (p64 <<< (2 * rpzp_pkg::Q14_SHIFT));
            default: begin
            end
          endcase
        end
        rpzp_pkg::ST_CHK: begin
          // point behind the camera answers all zero
          if (zf <= 64'sd0) done <= 1'b1;
          xq <= MW'(trunc_shift(xf, rpzp_pkg::FRAC_SHIFT));
          yq <= MW'(trunc_shift(yf, rpzp_pkg::FRAC_SHIFT));
          zq <= zf[rpzp_pkg::FRAC_SHIFT + rpzp_pkg::ZQ_W - 1:rpzp_pkg::FRAC_SHIFT];
        end
        rpzp_pkg::ST_INV: begin
          cnt <= '0;
          if (zq < rpzp_pkg::ZQ_MIN) inv <= rpzp_pkg::INV_ONE;
        end
        rpzp_pkg::ST_DIV: begin
          if (div_done) inv <= div_quot;
        end
        rpzp_pkg::ST_PROJ: begin
          cnt <= (cnt == rpzp_pkg::PROJ_LAST) ? 5'd0 : cnt + 5'd1;
          case (cnt)
            5'd1: zi <= signed'(prod[MW-1:0]);
            5'd2: sx <= (64'(HALF_W + int'(sh)) <<< rpzp_pkg::PROJ_SHIFT) + (p64 <<< 1);
            5'd3: sy <= (64'(HALF_H) <<< rpzp_pkg::PROJ_SHIFT) + p64;
            default: begin
            end
          endcase
        end
        rpzp_pkg::ST_INDEX: begin
          xp <= 24'(trunc_shift(sx, rpzp_pkg::PROJ_SHIFT));
          yp <= 24'(trunc_shift(sy, rpzp_pkg::PROJ_SHIFT));
        end
        rpzp_pkg::ST_ADDR: begin
          idx <= 40'(xp) + 40'(yp) * 40'(SCREEN_WIDTH);
        end
        rpzp_pkg::ST_LOOK: begin
          if (!in_range) begin
            done <= 1'b1;
            if (op == rpzp_pkg::CMD_READ) pixel_index <= idx[12:0];
          end
        end
        rpzp_pkg::ST_UPDATE: begin
          done        <= 1'b1;
          pixel_index <= idx[12:0];
          if (op == rpzp_pkg::CMD_READ) begin
            glyph_out <= ram_rdata[GW-1:0];
          end else begin
            drawn <= nearer;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a command is still in flight");

  a_drawn_done: assert property (@(posedge clk) disable iff (rst) drawn |-> done)
    else $error("drawn without a result strobe");

  a_start_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither started nor answered");

  a_glyph_read: assert property (@(posedge clk) disable iff (rst)
    (glyph_out != 8'd0) |-> (done && !drawn))
    else $error("glyph returned outside a read result");

endmodule

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for rotate_project_zbuffer_plot_top
// depends on rpzp_pkg and the plotter RTL; holds its own rotate/project/depth-test predictor
// drives a directed command table and then random phases under several register settings
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 160;
  localparam int H = 44;
  localparam int CELLS = W * H;
  localparam logic [7:0] BG = 8'd46;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] cmd = rpzp_pkg::CMD_NONE;
  logic signed [13:0] pos_i = '0, pos_j = '0, pos_k = '0;
  logic signed [7:0] shift_x = '0;
  logic [7:0] glyph = '0;
  logic [12:0] read_index = '0;
  logic cfg_we = 1'b0;
  logic [rpzp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rpzp_pkg::CFG_W-1:0] cfg_data = '0;
  logic done, drawn;
  logic [12:0] pixel_index;
  logic [7:0] glyph_out;

  rotate_project_zbuffer_plot_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .pos_i(pos_i), .pos_j(pos_j), .pos_k(pos_k), .shift_x(shift_x), .glyph(glyph),
    .read_index(read_index), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .drawn(drawn), .pixel_index(pixel_index), .glyph_out(glyph_out)
  );

  always #1 clk = ~clk;

  typedef struct {
    logic [1:0] c;
    logic signed [13:0] i, j, k;
    logic signed [7:0] sh;
    logic [7:0] g;
    logic [12:0] ri;
  } plot_cmd_t;

  typedef struct {
    logic dr;
    logic [12:0] pix;
    logic [7:0] gl;
  } plot_res_t;

  typedef struct {
    plot_cmd_t c;
    bit typed;
    plot_res_t r;
  } table_row_t;

  // predictor copy of the registers and the two stores
  rpzp_pkg::cfg_t cfg_m;
  logic [24:0] depth_m [CELLS];
  logic [7:0] glyph_m [CELLS];

  plot_res_t pending_q [$];
  int errors = 0;
  int n_drawn = 0, n_reads = 0, n_clears = 0, n_behind = 0, n_items = 0;
  longint cycles = 0;
  int hit_list [$];

  function automatic void clear_model();
    for (int n = 0; n < CELLS; n++) begin
      depth_m[n] = '0;
      glyph_m[n] = BG;
    end
  endfunction

  // clear, read, or rotation, perspective, depth test and store update for one command
  function automatic plot_res_t apply_cmd(plot_cmd_t c);
    plot_res_t r;
    longint i, j, k, sh, sa, ca, sb, cb, sc, cc, s, xf, yf, zf, xq, yq, zq, inv;
    longint sx, sy, xp, yp, idx;
    r = '{1'b0, 13'd0, 8'd0};
    if (c.c == rpzp_pkg::CMD_CLEAR) begin
      clear_model();
      n_clears++;
    end else if (c.c == rpzp_pkg::CMD_READ) begin
      r.pix = c.ri;
      if (c.ri < CELLS) r.gl = glyph_m[c.ri];
      n_reads++;
    end else if (c.c == rpzp_pkg::CMD_PLOT) begin
      i = c.i; j = c.j; k = c.k; sh = c.sh;
      sa = cfg_m.sin_a; ca = cfg_m.cos_a; sb = cfg_m.sin_b;
      cb = cfg_m.cos_b; sc = cfg_m.sin_c; cc = cfg_m.cos_c;
      s = 16384;
      xf = j*sa*sb*cc - k*ca*sb*cc + j*ca*sc*s + k*sa*sc*s + i*cb*cc*s;
      yf = j*ca*cc*s + k*sa*cc*s - j*sa*sb*sc + k*ca*sb*sc - i*cb*sc*s;
      zf = k*ca*cb*s - j*sa*cb*s + i*sb*s*s + longint'(cfg_m.camera_distance) * (64'sd1 << 50);
      if (zf <= 0) begin
        n_behind++;
        return r;
      end
      xq = xf / (64'sd1 << 34);
      yq = yf / (64'sd1 << 34);
      zq = zf / (64'sd1 << 34);
      inv = (zq < 65536) ? (64'sd1 << 24) : (64'sd1 << 40) / zq;
      sx = (W/2 + sh) * (64'sd1 << 40) + longint'(cfg_m.zoom) * inv * xq * 2;
      sy = (H/2) * (64'sd1 << 40) + longint'(cfg_m.zoom) * inv * yq;
      xp = sx / (64'sd1 << 40);
      yp = sy / (64'sd1 << 40);
      idx = xp + yp * W;
      if (idx >= 0 && idx < CELLS) begin
        r.pix = idx[12:0];
        if (inv[24:0] > depth_m[idx]) begin
          depth_m[idx] = inv[24:0];
          glyph_m[idx] = c.g;
          r.dr = 1'b1;
          n_drawn++;
          hit_list.push_back(int'(idx));
        end
      end
    end
    return r;
  endfunction

  // result checker: one strobe, one expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        plot_res_t e;
        e = pending_q.pop_front();
        if (drawn !== e.dr) begin
          $error("drawn: expected %0d actual %0d", e.dr, drawn); errors++;
        end
        if (pixel_index !== e.pix) begin
          $error("pixel_index: expected %0d actual %0d", e.pix, pixel_index); errors++;
        end
        if (glyph_out !== e.gl) begin
          $error("glyph_out: expected %0d actual %0d", e.gl, glyph_out); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  bit burst = 1'b0;

  // one command transfer; typed rows carry their own expectation
  task automatic send_cmd(plot_cmd_t c, bit typed, plot_res_t tr);
    plot_res_t p;
    int gap;
    start <= 1'b1;
    cmd <= c.c; pos_i <= c.i; pos_j <= c.j; pos_k <= c.k;
    shift_x <= c.sh; glyph <= c.g; read_index <= c.ri;
    do @(posedge clk); while (busy);
    p = apply_cmd(c);
    pending_q.push_back(typed ? tr : p);
    n_items++;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // one register write, then the write port goes idle before the model is updated
  task automatic write_reg(rpzp_pkg::reg_idx_t r, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (r)
      rpzp_pkg::REG_SIN_A: cfg_m.sin_a = v;
      rpzp_pkg::REG_COS_A: cfg_m.cos_a = v;
      rpzp_pkg::REG_SIN_B: cfg_m.sin_b = v;
      rpzp_pkg::REG_COS_B: cfg_m.cos_b = v;
      rpzp_pkg::REG_SIN_C: cfg_m.sin_c = v;
      rpzp_pkg::REG_COS_C: cfg_m.cos_c = v;
      rpzp_pkg::REG_CAMERA: cfg_m.camera_distance = v[7:0];
      rpzp_pkg::REG_ZOOM: cfg_m.zoom = v[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_trig(int sel);
    case (sel)
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic plot_cmd_t rand_cmd();
    plot_cmd_t c;
    int roll;
    c.i = $urandom; c.j = $urandom; c.k = $urandom;
    c.sh = $urandom; c.g = $urandom; c.ri = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      c.c = rpzp_pkg::CMD_PLOT;
      // mostly points near the origin so they land on screen
      if ($urandom_range(0, 3) != 0) begin
        c.i = $signed(14'($urandom_range(0, 4095))) - 14'sd2048;
        c.j = $signed(14'($urandom_range(0, 4095))) - 14'sd2048;
        c.k = $signed(14'($urandom_range(0, 4095))) - 14'sd2048;
        c.sh = $signed(8'($urandom_range(0, 63))) - 8'sd32;
      end
    end else if (roll < 93) begin
      c.c = rpzp_pkg::CMD_READ;
      if (hit_list.size() > 0 && $urandom_range(0, 2) != 0)
        c.ri = 13'(hit_list[$urandom_range(0, hit_list.size() - 1)]);
    end else if (roll < 95) begin
      c.c = rpzp_pkg::CMD_CLEAR;
    end else begin
      c.c = rpzp_pkg::CMD_NONE;
    end
    return c;
  endfunction

  table_row_t dir_tbl [$];

  initial begin
    plot_res_t none;
    plot_cmd_t c;
    none = '{1'b0, 13'd0, 8'd0};
    cfg_m = '{16'sd0, rpzp_pkg::ONE_Q14, 16'sd0, rpzp_pkg::ONE_Q14, 16'sd0,
              rpzp_pkg::ONE_Q14, rpzp_pkg::CAM_RESET, rpzp_pkg::ZOOM_RESET};
    clear_model();

    dir_tbl = '{
      '{'{rpzp_pkg::CMD_READ, 0, 0, 0, 0, 0, 13'd0}, 1, '{0, 13'd0, BG}},
      '{'{rpzp_pkg::CMD_READ, 0, 0, 0, 0, 0, 13'd7039}, 1, '{0, 13'd7039, BG}},
      '{'{rpzp_pkg::CMD_READ, 0, 0, 0, 0, 0, 13'd7040}, 1, '{0, 13'd7040, 8'd0}},
      '{'{rpzp_pkg::CMD_READ, 0, 0, 0, 0, 0, 13'd8191}, 1, '{0, 13'd8191, 8'd0}},
      '{'{rpzp_pkg::CMD_NONE, -1, -1, -1, -1, 8'hff, 13'h1fff}, 1, '{0, 13'd0, 8'd0}},
      '{'{rpzp_pkg::CMD_PLOT, 0, 0, 0, 0, 8'd65, 0}, 1, '{1, 13'd3600, 8'd0}},
      '{'{rpzp_pkg::CMD_PLOT, 0, 0, 0, 0, 8'd66, 0}, 1, '{0, 13'd3600, 8'd0}},
      '{'{rpzp_pkg::CMD_READ, 0, 0, 0, 0, 0, 13'd3600}, 1, '{0, 13'd3600, 8'd65}},
      '{'{rpzp_pkg::CMD_PLOT, 0, 0, -14'sd8192, 0, 8'd255, 0}, 0, none},
      '{'{rpzp_pkg::CMD_PLOT, 0, 0, 14'sd8191, 0, 8'd0, 0}, 0, none},
      '{'{rpzp_pkg::CMD_PLOT, 14'sd8191, 14'sd8191, 0, 8'sd127, 8'd1, 0}, 0, none},
      '{'{rpzp_pkg::CMD_PLOT, -14'sd8192, -14'sd8192, 0, -8'sd128, 8'd2, 0}, 0, none},
      '{'{rpzp_pkg::CMD_PLOT, 14'sd8191, -14'sd8192, 14'sd8191, 0, 8'd3, 0}, 0, none},
      '{'{rpzp_pkg::CMD_PLOT, -14'sd8192, 14'sd8191, -14'sd8192, 8'sd5, 8'd4, 0}, 0, none},
      '{'{rpzp_pkg::CMD_READ, 0, 0, 0, 0, 0, 13'd3600}, 0, none},
      '{'{rpzp_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0}, 1, '{0, 13'd0, 8'd0}},
      '{'{rpzp_pkg::CMD_READ, 0, 0, 0, 0, 0, 13'd3600}, 1, '{0, 13'd3600, BG}},
      '{'{rpzp_pkg::CMD_PLOT, 0, 0, 0, 0, 8'd67, 0}, 1, '{1, 13'd3600, 8'd0}}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // the post-reset clearing sweep holds busy
    do @(posedge clk); while (busy);

    foreach (dir_tbl[n]) send_cmd(dir_tbl[n].c, dir_tbl[n].typed, dir_tbl[n].r);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(rpzp_pkg::REG_SIN_A, rand_trig(ph < 3 ? ph : 3));
      write_reg(rpzp_pkg::REG_COS_A, rand_trig(ph < 3 ? 2 - ph : 3));
      write_reg(rpzp_pkg::REG_SIN_B, rand_trig(ph == 1 ? 1 : 3));
      write_reg(rpzp_pkg::REG_COS_B, rand_trig(ph == 0 ? 0 : 3));
      write_reg(rpzp_pkg::REG_SIN_C, rand_trig(ph == 2 ? 0 : 3));
      write_reg(rpzp_pkg::REG_COS_C, rand_trig(ph == 2 ? 1 : 3));
      // camera 0 and 1 reach points behind the camera and the saturated 1/z
      case (ph)
        0: begin
          write_reg(rpzp_pkg::REG_CAMERA, 16'($urandom) & 16'hff00);
          write_reg(rpzp_pkg::REG_ZOOM, 16'd255);
        end
        1: begin
          write_reg(rpzp_pkg::REG_CAMERA, 16'hff01);
          write_reg(rpzp_pkg::REG_ZOOM, 16'h00ff);
        end
        2: begin
          write_reg(rpzp_pkg::REG_CAMERA, 16'd255);
          write_reg(rpzp_pkg::REG_ZOOM, 16'd0);
        end
        3: begin
          write_reg(rpzp_pkg::REG_CAMERA, 16'd255);
          write_reg(rpzp_pkg::REG_ZOOM, 16'd255);
        end
        default: begin
          write_reg(rpzp_pkg::REG_CAMERA, 16'($urandom));
          write_reg(rpzp_pkg::REG_ZOOM, 16'($urandom));
        end
      endcase
      for (int n = 0; n < 64; n++) begin
        if (n % 16 == 0) burst = ($urandom_range(0, 2) == 0);
        c = rand_cmd();
        send_cmd(c, 1'b0, none);
      end
      burst = 1'b0;
      drain();
    end

    $display("tb: %0d commands, %0d points drawn, %0d behind camera, %0d reads, %0d clears",
             n_items, n_drawn, n_behind, n_reads, n_clears);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
